// ===== hdl/kmc_pkg.sv =====
// Shared constants and types of the keypad mode controller.
`default_nettype none
package kmc_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned FlagW   = 3;
  localparam int unsigned MacroW  = 8;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned NumBtn  = 4;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned DivSteps = MacroW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [CmdW-1:0] CMD_SCAN     = 2'd0;
  localparam logic [CmdW-1:0] CMD_BLACKOUT = 2'd1;
  localparam logic [CmdW-1:0] CMD_SET      = 2'd2;

  localparam logic [ModeW-1:0] MODE_AUTO = 2'd0;
  localparam logic [ModeW-1:0] MODE_MANU = 2'd1;
  localparam logic [ModeW-1:0] MODE_SEQ  = 2'd2;
  localparam logic [ModeW-1:0] MODE_LAMP = 2'd3;

  localparam logic [FlagW-1:0] FLAG_NONE      = 3'd0;
  localparam logic [FlagW-1:0] FLAG_PRESS     = 3'd1;
  localparam logic [FlagW-1:0] FLAG_LONG      = 3'd2;
  localparam logic [FlagW-1:0] FLAG_REL_SHORT = 3'd3;
  localparam logic [FlagW-1:0] FLAG_REL_LONG  = 3'd4;

  // Button combinations as a mask of engaged buttons, button one in bit 0.
  localparam logic [NumBtn-1:0] COMBO_1  = 4'b0001;
  localparam logic [NumBtn-1:0] COMBO_2  = 4'b0010;
  localparam logic [NumBtn-1:0] COMBO_3  = 4'b0100;
  localparam logic [NumBtn-1:0] COMBO_4  = 4'b1000;
  localparam logic [NumBtn-1:0] COMBO_14 = 4'b1001;
  localparam logic [NumBtn-1:0] COMBO_23 = 4'b0110;

  localparam logic [LevelW-1:0] LAMP_FULL       = 8'd255;
  localparam logic [LevelW-1:0] GRAD_RESET      = 8'd127;
  localparam logic [MacroW-1:0] MACRO_MAX_RESET = 8'd16;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
  } kmc_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/kmc_ctrl.sv =====
// Sequencing state machine: capture, remainder iterations, state update, output handshake.
`default_nettype none
module kmc_ctrl
  import kmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output kmc_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  logic            out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.apply    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.apply) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/kmc_datapath.sv =====
// Item capture, bit-serial remainder unit, mode and lamp state, and result register.
`default_nettype none
module kmc_datapath
  import kmc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kmc_cmd_t            cmd,
  input  wire logic [CmdW-1:0]     in_cmd,
  input  wire logic [InDataW-1:0]  in_data,
  input  wire logic                cfg_we,
  input  wire logic [MacroW-1:0]   cfg_data,
  output logic [OutDataW-1:0]      out_data
);

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ModeW-1:0]  prev_mode;
    logic              lock;
    logic [MacroW-1:0] running;
    logic [MacroW-1:0] shown;
    logic              lit;
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] grad;
    logic              save;
  } kmc_st_t;

  function automatic kmc_st_t chg_mode(kmc_st_t s, logic [ModeW-1:0] x);
    kmc_st_t r;
    r = s;
    if (s.mode != x) begin
      if (s.mode == MODE_LAMP) begin
        r.save  = 1'b1;
        r.lit   = 1'b0;
        r.level = '0;
      end
      r.mode = x;
    end
    return r;
  endfunction

  function automatic kmc_st_t lamp_set(kmc_st_t s, logic [LevelW-1:0] v);
    kmc_st_t r;
    r = s;
    r.lit   = 1'b1;
    r.level = v;
    return r;
  endfunction

  function automatic kmc_st_t lamp_toggle(kmc_st_t s, logic [LevelW-1:0] v);
    kmc_st_t r;
    r = s;
    if (s.lit) begin
      r.lit   = 1'b0;
      r.level = '0;
    end else begin
      r = lamp_set(s, v);
    end
    return r;
  endfunction

  function automatic kmc_st_t grad_dn(kmc_st_t s);
    kmc_st_t r;
    r = s;
    if (r.grad != '0) begin
      r.grad = r.grad - 1'b1;
    end
    return lamp_set(r, r.grad);
  endfunction

  function automatic kmc_st_t grad_up(kmc_st_t s);
    kmc_st_t r;
    r = s;
    if (r.grad != LAMP_FULL) begin
      r.grad = r.grad + 1'b1;
    end
    return lamp_set(r, r.grad);
  endfunction

  function automatic kmc_st_t sel_macro(kmc_st_t s, logic [MacroW-1:0] v);
    kmc_st_t r;
    r = s;
    r.running = v;
    r.shown   = v;
    return chg_mode(r, MODE_SEQ);
  endfunction

  kmc_st_t                      cur;
  kmc_st_t                      st;
  logic [MacroW-1:0]            macro_max;
  logic [CmdW-1:0]              cmd_q;
  logic [NumBtn-1:0][FlagW-1:0] btn;
  logic [MacroW-1:0]            div_rem;
  logic [MacroW-1:0]            div_sh;
  logic [MacroW:0]              div_try;
  logic [MacroW-1:0]            mm_last;
  logic [NumBtn-1:0]            engaged;
  logic                         has_press;
  logic                         has_long;
  logic                         has_rel;
  logic                         has_short;
  logic                         has_rlong;
  logic                         scan_ok;
  logic                         shrt;
  logic                         consume_next;

  assign mm_last = macro_max - 1'b1;
  assign div_try = {div_rem, div_sh[MacroW-1]};

  always_comb begin
    has_press = 1'b0;
    has_long  = 1'b0;
    has_short = 1'b0;
    has_rlong = 1'b0;
    for (int i = 0; i < NumBtn; i++) begin
      engaged[i] = (btn[i] != FLAG_NONE) && (btn[i] <= FLAG_REL_LONG);
      has_press  = has_press | (btn[i] == FLAG_PRESS);
      has_long   = has_long  | (btn[i] == FLAG_LONG);
      has_short  = has_short | (btn[i] == FLAG_REL_SHORT);
      has_rlong  = has_rlong | (btn[i] == FLAG_REL_LONG);
    end
    has_rel = has_short | has_rlong;
    scan_ok = (engaged != '0) && !has_press && !(has_long && has_rel);
    shrt    = has_short && !has_rlong;
  end

  always_comb begin
    st           = cur;
    st.save      = 1'b0;
    consume_next = 1'b0;
    case (cmd_q)
      CMD_SCAN: begin
        if (scan_ok) begin
          consume_next = 1'b1;
          if (cur.lock) begin
            case (engaged)
              COMBO_1, COMBO_4: begin
                if (shrt) begin
                  if (st.mode == MODE_LAMP) begin
                    st.save = 1'b1;
                    st = chg_mode(st, st.prev_mode);
                  end else if (st.mode == MODE_SEQ) begin
                    st = sel_macro(st, mm_last);
                  end
                end
              end
              COMBO_2: st = shrt ? grad_dn(st) : lamp_toggle(st, st.grad);
              COMBO_3: st = shrt ? grad_up(st) : lamp_toggle(st, LAMP_FULL);
              COMBO_14: st.lock = 1'b0;
              COMBO_23: begin
                if (st.mode == MODE_LAMP) begin
                  st = chg_mode(st, st.prev_mode);
                end else begin
                  st.prev_mode = st.mode;
                  st = chg_mode(st, MODE_LAMP);
                  st = lamp_set(st, st.grad);
                end
              end
              default: ;
            endcase
          end else begin
            case (engaged)
              COMBO_1: begin
                if (shrt) begin
                  case (st.mode)
                    MODE_AUTO: st.lock = 1'b1;
                    MODE_MANU: st = chg_mode(st, MODE_AUTO);
                    MODE_SEQ: begin
                      st = sel_macro(st, mm_last);
                      st = chg_mode(st, MODE_MANU);
                    end
                    default: st = chg_mode(st, MODE_MANU);
                  endcase
                end else begin
                  st = sel_macro(st, mm_last);
                end
              end
              COMBO_2: begin
                if (shrt) begin
                  if (st.mode == MODE_MANU) begin
                    st.shown = (st.shown == '0) ? mm_last : st.shown - 1'b1;
                  end else if (st.mode == MODE_LAMP) begin
                    st = grad_dn(st);
                  end else if (st.mode == MODE_AUTO) begin
                    st = chg_mode(st, MODE_MANU);
                  end
                end else begin
                  st = lamp_toggle(st, st.grad);
                end
              end
              COMBO_3: begin
                if (shrt) begin
                  if (st.mode == MODE_MANU) begin
                    if (({1'b0, st.shown} + 1'b1) >= {1'b0, macro_max}) begin
                      st.shown = '0;
                    end else begin
                      st.shown = st.shown + 1'b1;
                    end
                  end else if (st.mode == MODE_LAMP) begin
                    st = grad_up(st);
                  end else if (st.mode == MODE_AUTO) begin
                    st = chg_mode(st, MODE_MANU);
                  end
                end else begin
                  st = lamp_toggle(st, LAMP_FULL);
                end
              end
              COMBO_4: begin
                if (shrt) begin
                  if (st.mode == MODE_MANU) begin
                    st.running = div_rem;
                  end else if (st.mode == MODE_LAMP) begin
                    st.save  = 1'b1;
                    st.mode  = MODE_MANU;
                    st.lit   = 1'b0;
                    st.level = '0;
                  end
                end else begin
                  st.running = div_rem;
                  st = chg_mode(st, MODE_MANU);
                  st.lock = 1'b1;
                end
              end
              COMBO_14: st.lock = 1'b1;
              COMBO_23: st = chg_mode(st, MODE_LAMP);
              default: ;
            endcase
          end
        end
      end
      CMD_BLACKOUT: st = sel_macro(st, mm_last);
      CMD_SET:      st = sel_macro(st, div_rem);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mode      <= MODE_AUTO;
      cur.prev_mode <= MODE_AUTO;
      cur.lock      <= 1'b1;
      cur.running   <= '0;
      cur.shown     <= '0;
      cur.lit       <= 1'b0;
      cur.level     <= '0;
      cur.grad      <= GRAD_RESET;
      cur.save      <= 1'b0;
      macro_max     <= MACRO_MAX_RESET;
    end else begin
      if (cmd.apply) begin
        cur <= st;
      end
      if (cfg_we) begin
        macro_max <= (cfg_data == '0) ? MacroW'(1) : cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= in_cmd;
      btn[0]  <= in_data[2:0];
      btn[1]  <= in_data[5:3];
      btn[2]  <= in_data[8:6];
      btn[3]  <= in_data[11:9];
      div_rem <= '0;
      div_sh  <= (in_cmd == CMD_SET) ? in_data[19:12] : cur.shown;
    end else if (cmd.div_step) begin
      div_sh <= {div_sh[MacroW-2:0], 1'b0};
      if (div_try >= {1'b0, macro_max}) begin
        div_rem <= MacroW'(div_try - {1'b0, macro_max});
      end else begin
        div_rem <= div_try[MacroW-1:0];
      end
    end
    if (cmd.apply) begin
      out_data <= {2'b00, consume_next, st.save, st.grad,
                   (st.lit ? st.level : LevelW'(0)), st.lit,
                   st.shown, st.running, st.lock, st.mode};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/keypad_mode_controller.sv =====
// Top level of the four-button keypad mode controller.
// The slave channel takes one beat per button scan or external order: s_tuser holds
// the order kind and s_tdata the four gesture flags and the requested macro index.
// Each accepted beat yields exactly one result beat on the master channel holding
// the mode, lock, macro, lamp and pulse fields as they stand after that beat.
// The configuration channel writes the macro count; a zero is stored as one.
// The beat is captured at the accepting edge, then the one-bit-per-cycle remainder unit
// works through all eight bits of the index, and the update state then applies the
// result and raises m_tvalid once the output register is free.
// A new beat is taken only after the previous one has been applied; s_tready is high
// only while no beat is in work.
// The result sits in an output register, so a new beat is taken while a result waits;
// if the receiver stalls, the following update holds until the register is free.
// Synchronous reset locks the keypad, selects auto mode, turns the lamp off, sets the
// stored brightness to 127 and the macro count to 16, and clears m_tvalid.
`default_nettype none
module keypad_mode_controller
  import kmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [2:0] button_one, [5:3] button_two, [8:6] button_three, [11:9] button_four,
  // [19:12] macro_index, [23:20] zero
  input  wire logic [InDataW-1:0]   s_tdata,
  // [1:0] cmd
  input  wire logic [CmdW-1:0]      s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [1:0] mode, [2] locked, [10:3] active_macro, [18:11] preview_macro, [19] lamp_on,
  // [27:20] lamp_level, [35:28] lamp_preset, [36] save_grad, [37] consume, [39:38] zero
  output logic [OutDataW-1:0]       m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [MacroW-1:0]    cfg_data
);

  kmc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  kmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  kmc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_cmd   (s_tuser),
    .in_data  (s_tdata),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (m_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/kmc_checker.sv =====
// Port-level checks of the keypad mode controller and their binding to the top level.
`default_nettype none
module kmc_checker
  import kmc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OutDataW-1:0] m_tdata
);

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low after reset");

  a_one_beat_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat accepted while one is in work");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

  a_dark_lamp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[19] |-> m_tdata[27:20] == '0)
    else $error("lamp level nonzero with lamp off");

endmodule

bind keypad_mode_controller kmc_checker u_kmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
